// ===== rtl/core/mbe_pkg.sv =====
// Shared types and constants for the multipart body extractor.
`default_nettype none

package mbe_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_DASH = 8'h2D;

  // Boundary word registers present on the config port
  localparam int NUM_WORD_REGS = 6;

  // Result queue between parser and output stage (power of two)
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_BLEN   = 3'd0,
    REG_HLINES = 3'd1,
    REG_WORD0  = 3'd2,
    REG_WORD1  = 3'd3,
    REG_WORD2  = 3'd4,
    REG_WORD3  = 3'd5,
    REG_WORD4  = 3'd6,
    REG_WORD5  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_CRLF   = 2'd1,
    ERR_NO_BLANK  = 2'd2,
    ERR_EARLY_END = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_CRLF  = 3'd1,
    PH_HEAD  = 3'd2,
    PH_BLANK = 3'd3,
    PH_BODY  = 3'd4,
    PH_TERM  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    SQ_EVAL   = 2'd0,
    SQ_REPLAY = 2'd1,
    SQ_TAIL   = 2'd2,
    SQ_EOS    = 2'd3
  } seq_e;

  // One result op: body byte, completion or error (code in data[1:0])
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/multipart_body_extractor_unit.sv =====
// Multipart body extractor top level. Bytes of a multipart/form-data body
// enter through a queue-style port (push/full) and the file body comes out
// through another (empty/pop), one result transaction per byte of body plus
// a completion or error status. Set boundary_length, header_lines and the
// boundary words over the config port while the unit is idle. A byte that
// causes at most one result streams through at one byte per cycle while the
// result queue has room; one that causes more holds the input until all are
// issued, as the front end issues one result op per cycle into the queue
// while it has room. A terminator mismatch after k matched characters replays
// CR, LF and the k characters, then the breaking byte unless it is a CR,
// then any end-of-stream error. A four-entry result queue lets the input
// keep flowing while the consumer holds off pop. No clearing pass after reset.
`default_nettype none

module multipart_body_extractor_unit #(
  parameter int MAX_BOUNDARY = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);
  import mbe_pkg::*;

  localparam int PW = $clog2(MAX_BOUNDARY + 5);

  logic [5:0]    blen;
  logic [2:0]    hlines;
  logic [PW-1:0] pat_addr;
  logic [7:0]    pat_char;
  op_t           op;
  logic          op_push;
  logic          q_rdy;

  // config registers, boundary lookup
  mbe_cfg #(
    .MAX_BOUNDARY (MAX_BOUNDARY)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .blen_o      (blen),
    .hlines_o    (hlines),
    .pat_addr_i  (pat_addr),
    .pat_char_o  (pat_char)
  );

  // parser: framing state plus op sequencing
  mbe_front #(
    .MAX_BOUNDARY (MAX_BOUNDARY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_byte_i    (in_byte_i),
    .first_byte_i (first_byte_i),
    .final_byte_i (final_byte_i),
    .full_o       (full),
    .blen_i       (blen),
    .hlines_i     (hlines),
    .pat_addr_o   (pat_addr),
    .pat_char_i   (pat_char),
    .op_o         (op),
    .op_push_o    (op_push),
    .q_rdy_i      (q_rdy)
  );

  // result queue and field formatting
  mbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .op_push_i     (op_push),
    .q_rdy_o       (q_rdy),
    .empty_o       (empty),
    .pop_i         (pop),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

`ifndef ASSERT_OFF
  // the front end never writes into a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_push |-> q_rdy)
    else $error("result op pushed into full queue");

  // completion and error statuses always close the run of their byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_BODY) |-> last_of_run_o)
    else $error("status result not marked last of run");

  // a status op leaves the parser with nothing more to say for that byte
  a_status_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_push && op.kind != KIND_BODY) |-> op.last)
    else $error("status op pushed with more ops pending");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mbe_cfg.sv =====
// Configuration registers and boundary pattern lookup.
`default_nettype none

module mbe_cfg #(
  parameter int MAX_BOUNDARY = 48,
  localparam int PW = $clog2(MAX_BOUNDARY + 5)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_wdata_i,
  output logic [5:0]    blen_o,
  output logic [2:0]    hlines_o,
  input  logic [PW-1:0] pat_addr_i,
  output logic [7:0]    pat_char_o
);
  import mbe_pkg::*;

  localparam int WORDS = (MAX_BOUNDARY + 7) / 8;

  logic [5:0]          blen_q;
  logic [2:0]          hlines_q;
  logic [WORDS*64-1:0] bvec;
  logic [PW-1:0]       ci;
  logic [PW-1:0]       lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q   <= 6'd1;
      hlines_q <= 3'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_BLEN) begin
        blen_q <= cfg_wdata_i[5:0];
      end
      if (cfg_idx_i == REG_HLINES) begin
        hlines_q <= cfg_wdata_i[2:0];
      end
    end
  end

  for (genvar w = 0; w < WORDS; w++) begin : g_word
    if (w < NUM_WORD_REGS) begin : g_reg
      logic [63:0] word_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          word_q <= '0;
        end else if (cfg_we_i && cfg_idx_i == 3'(int'(REG_WORD0) + w)) begin
          word_q <= cfg_wdata_i;
        end
      end
      assign bvec[w*64 +: 64] = word_q;
    end else begin : g_zero
      // no register index reaches these characters
      assign bvec[w*64 +: 64] = '0;
    end
  end

  // lengths above the supported maximum clamp to it
  assign blen_o   = ({1'b0, blen_q} > 7'(MAX_BOUNDARY)) ? 6'(MAX_BOUNDARY) : blen_q;
  assign hlines_o = hlines_q;

  // character p of "--" boundary "--"
  assign ci  = pat_addr_i - PW'(2);
  assign lim = PW'(blen_o) + PW'(2);

  always_comb begin
    if (pat_addr_i < PW'(2) || pat_addr_i >= lim) begin
      pat_char_o = CH_DASH;
    end else begin
      pat_char_o = bvec[{ci, 3'b000} +: 8];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mbe_front.sv =====
// Parser front end: takes bytes, tracks the framing and issues result ops.
`default_nettype none

module mbe_front #(
  parameter int MAX_BOUNDARY = 48,
  localparam int PW = $clog2(MAX_BOUNDARY + 5)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     in_byte_i,
  input  logic           first_byte_i,
  input  logic           final_byte_i,
  output logic           full_o,
  input  logic [5:0]     blen_i,
  input  logic [2:0]     hlines_i,
  output logic [PW-1:0]  pat_addr_o,
  input  logic [7:0]     pat_char_i,
  output mbe_pkg::op_t   op_o,
  output logic           op_push_o,
  input  logic           q_rdy_i
);
  import mbe_pkg::*;

  // held item
  logic       item_vld_q;
  logic [7:0] item_byte_q;
  logic       item_first_q;
  logic       item_final_q;

  // parser state
  phase_e        phase_q, phase_d;
  logic [PW-1:0] mc_q, mc_d;
  logic [2:0]    ls_q, ls_d;
  logic          pcr_q, pcr_d;
  logic          fin_q, fin_d;

  // op sequencer
  seq_e          seq_q, seq_d;
  logic [PW-1:0] rc_q, rc_d;
  logic [PW-1:0] rep_end_q, rep_end_d;
  logic          tail_q, tail_d;
  logic          eos_q, eos_d;

  // effective (post restart) state and handle() results
  phase_e        ph;
  logic [PW-1:0] mc;
  logic [2:0]    ls;
  logic          pcr;
  logic          fin;
  logic [PW-1:0] mc_inc;
  logic [2:0]    ls_inc;
  logic          m1;
  logic          m2;
  logic          hfin;
  logic          op0_vld;
  op_t           op0;
  logic          go_rep;
  logic          tail;
  logic          eos;
  err_e          fcode;

  logic          emit;
  logic          commit;
  logic          done;
  logic          last_rep;
  logic          accept;
  op_t           op;

  assign pat_addr_o = (seq_q == SQ_REPLAY) ? rc_q - PW'(2) :
                      (item_first_q ? '0 : mc_q);

  // single-byte parser step
  always_comb begin
    ph      = item_first_q ? PH_SEEK : phase_q;
    mc      = item_first_q ? '0 : mc_q;
    ls      = item_first_q ? '0 : ls_q;
    pcr     = item_first_q ? 1'b0 : pcr_q;
    fin     = item_first_q ? 1'b0 : fin_q;
    phase_d = ph;
    mc_d    = mc;
    ls_d    = ls;
    pcr_d   = pcr;
    fin_d   = fin;
    mc_inc  = mc + PW'(1);
    ls_inc  = ls + 3'd1;
    m1      = (item_byte_q == pat_char_i);
    m2      = 1'b0;
    hfin    = 1'b0;
    op0_vld = 1'b0;
    op0     = '{kind: KIND_BODY, data: item_byte_q, last: 1'b0};
    go_rep  = 1'b0;
    tail    = 1'b0;
    eos     = 1'b0;
    fcode   = (ph == PH_CRLF) ? ERR_NO_CRLF : ERR_NO_BLANK;

    if (!fin) begin
      case (ph)
        PH_SEEK: begin
          if (!m1 && mc != '0) begin
            // restart and retry the byte against the first dash
            m2     = (item_byte_q == CH_DASH);
            mc_inc = PW'(1);
          end else begin
            m2 = m1;
          end
          if (m2) begin
            if (mc_inc == PW'(blen_i) + PW'(2)) begin
              mc_d    = '0;
              pcr_d   = 1'b0;
              phase_d = PH_CRLF;
            end else begin
              mc_d = mc_inc;
            end
          end else begin
            mc_d = '0;
          end
        end
        PH_CRLF, PH_BLANK: begin
          if (!pcr) begin
            if (item_byte_q == CH_CR) begin
              pcr_d = 1'b1;
            end else begin
              hfin    = 1'b1;
              op0_vld = 1'b1;
              op0     = '{kind: KIND_ERROR, data: {6'b0, fcode}, last: 1'b0};
            end
          end else if (item_byte_q == CH_LF) begin
            pcr_d = 1'b0;
            if (ph == PH_BLANK) begin
              phase_d = PH_BODY;
            end else begin
              ls_d    = '0;
              phase_d = (hlines_i == 3'd0) ? PH_BLANK : PH_HEAD;
            end
          end else begin
            hfin    = 1'b1;
            op0_vld = 1'b1;
            op0     = '{kind: KIND_ERROR, data: {6'b0, fcode}, last: 1'b0};
          end
        end
        PH_HEAD: begin
          if (pcr && item_byte_q == CH_LF) begin
            pcr_d = 1'b0;
            ls_d  = ls_inc;
            if (ls_inc >= hlines_i) begin
              phase_d = PH_BLANK;
            end
          end else begin
            pcr_d = (item_byte_q == CH_CR);
          end
        end
        PH_BODY: begin
          if (pcr) begin
            pcr_d = 1'b0;
            if (item_byte_q == CH_LF) begin
              mc_d    = '0;
              phase_d = PH_TERM;
            end else begin
              // lone CR goes out, then the byte as a body byte
              op0_vld = 1'b1;
              op0     = '{kind: KIND_BODY, data: CH_CR, last: 1'b0};
              tail    = (item_byte_q != CH_CR);
              pcr_d   = (item_byte_q == CH_CR);
            end
          end else if (item_byte_q == CH_CR) begin
            pcr_d = 1'b1;
          end else begin
            op0_vld = 1'b1;
          end
        end
        PH_TERM: begin
          if (m1) begin
            mc_d = mc_inc;
            if (mc_inc == PW'(blen_i) + PW'(4)) begin
              hfin    = 1'b1;
              op0_vld = 1'b1;
              op0     = '{kind: KIND_DONE, data: 8'd0, last: 1'b0};
            end
          end else begin
            // replay CR LF and the matched characters, then the byte
            op0_vld = 1'b1;
            op0     = '{kind: KIND_BODY, data: CH_CR, last: 1'b0};
            go_rep  = 1'b1;
            mc_d    = '0;
            phase_d = PH_BODY;
            pcr_d   = (item_byte_q == CH_CR);
            tail    = (item_byte_q != CH_CR);
          end
        end
        default: begin
          phase_d = PH_SEEK;
        end
      endcase
      eos   = !hfin && item_final_q;
      fin_d = hfin || eos;
    end
  end

  // op sequencer: one op per cycle into the queue while it has room
  always_comb begin
    seq_d     = seq_q;
    rc_d      = rc_q;
    rep_end_d = rep_end_q;
    tail_d    = tail_q;
    eos_d     = eos_q;
    emit      = 1'b0;
    commit    = 1'b0;
    done      = 1'b0;
    last_rep  = (rc_q == rep_end_q + PW'(1));
    op        = op0;

    case (seq_q)
      SQ_EVAL: begin
        if (op0_vld) begin
          emit    = 1'b1;
          op.last = !(go_rep || tail || eos);
        end else if (eos) begin
          emit = 1'b1;
          op   = '{kind: KIND_ERROR, data: {6'b0, ERR_EARLY_END}, last: 1'b1};
        end
        if (item_vld_q && (!emit || q_rdy_i)) begin
          commit    = 1'b1;
          rc_d      = PW'(1);
          rep_end_d = mc;
          tail_d    = tail;
          eos_d     = eos;
          if (go_rep) begin
            seq_d = SQ_REPLAY;
          end else if (op0_vld && tail) begin
            seq_d = SQ_TAIL;
          end else if (op0_vld && eos) begin
            seq_d = SQ_EOS;
          end else begin
            done = 1'b1;
          end
        end
      end
      SQ_REPLAY: begin
        emit = 1'b1;
        op   = '{kind: KIND_BODY,
                 data: (rc_q == PW'(1)) ? CH_LF : pat_char_i,
                 last: last_rep && !tail_q && !eos_q};
        if (q_rdy_i) begin
          if (last_rep) begin
            if (tail_q) begin
              seq_d = SQ_TAIL;
            end else if (eos_q) begin
              seq_d = SQ_EOS;
            end else begin
              seq_d = SQ_EVAL;
              done  = 1'b1;
            end
          end else begin
            rc_d = rc_q + PW'(1);
          end
        end
      end
      SQ_TAIL: begin
        emit = 1'b1;
        op   = '{kind: KIND_BODY, data: item_byte_q, last: !eos_q};
        if (q_rdy_i) begin
          if (eos_q) begin
            seq_d = SQ_EOS;
          end else begin
            seq_d = SQ_EVAL;
            done  = 1'b1;
          end
        end
      end
      SQ_EOS: begin
        emit = 1'b1;
        op   = '{kind: KIND_ERROR, data: {6'b0, ERR_EARLY_END}, last: 1'b1};
        if (q_rdy_i) begin
          seq_d = SQ_EVAL;
          done  = 1'b1;
        end
      end
      default: begin
        seq_d = SQ_EVAL;
      end
    endcase
  end

  assign full_o    = item_vld_q && !done;
  assign accept    = push_i && !full_o;
  assign op_o      = op;
  assign op_push_o = item_vld_q && emit && q_rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      seq_q      <= SQ_EVAL;
      phase_q    <= PH_SEEK;
      mc_q       <= '0;
      ls_q       <= '0;
      pcr_q      <= 1'b0;
      fin_q      <= 1'b0;
      rc_q       <= '0;
      rep_end_q  <= '0;
      tail_q     <= 1'b0;
      eos_q      <= 1'b0;
    end else begin
      if (accept) begin
        item_vld_q <= 1'b1;
      end else if (done) begin
        item_vld_q <= 1'b0;
      end
      seq_q     <= seq_d;
      rc_q      <= rc_d;
      rep_end_q <= rep_end_d;
      tail_q    <= tail_d;
      eos_q     <= eos_d;
      if (commit) begin
        phase_q <= phase_d;
        mc_q    <= mc_d;
        ls_q    <= ls_d;
        pcr_q   <= pcr_d;
        fin_q   <= fin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_byte_q  <= in_byte_i;
      item_first_q <= first_byte_i;
      item_final_q <= final_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mbe_back.sv =====
// Result queue and output formatting.
`default_nettype none

module mbe_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mbe_pkg::op_t op_i,
  input  logic         op_push_i,
  output logic         q_rdy_o,
  output logic         empty_o,
  input  logic         pop_i,
  output logic [1:0]   kind_o,
  output logic [7:0]   out_byte_o,
  output logic [1:0]   error_code_o,
  output logic         last_of_run_o
);
  import mbe_pkg::*;

  op_t             q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_q;
  logic [Q_AW-1:0] rd_q;
  logic [Q_CW-1:0] cnt_q;
  logic            pop_ok;
  op_t             head;

  assign q_rdy_o = (cnt_q != Q_CW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign pop_ok  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (op_push_i) begin
        wr_q <= wr_q + Q_AW'(1);
      end
      if (pop_ok) begin
        rd_q <= rd_q + Q_AW'(1);
      end
      cnt_q <= cnt_q + Q_CW'(op_push_i) - Q_CW'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_push_i) begin
      q_mem[wr_q] <= op_i;
    end
  end

  assign head          = q_mem[rd_q];
  assign kind_o        = head.kind;
  assign out_byte_o    = (head.kind == KIND_BODY) ? head.data : 8'd0;
  assign error_code_o  = (head.kind == KIND_ERROR) ? head.data[1:0] : ERR_NONE;
  assign last_of_run_o = head.last;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the multipart body extractor unit.
`timescale 1ns / 100ps

module testbench;
  import mbe_pkg::*;

  localparam int MAX_BOUNDARY  = 48;
  localparam int SETTLE_CYCLES = 12;         // front end plus result queue, with margin
  localparam int ITEM_GOAL     = 420;        // random bytes to push
  localparam int CALM_FROM     = 340;        // no idling on either side past this point
  localparam int LIMIT_NS      = 2_000_000;  // watchdog limit in nanoseconds

  // One result transaction as seen on the output side
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
    logic       last;
  } result_t;

  // One byte transaction on the input side
  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       fin;
  } stim_t;

  // Holds a private copy of the parser state and registers, works out the
  // results each accepted byte must produce and checks them in order.
  class extractor_scoreboard;
    logic [5:0]  bound_len;
    logic [2:0]  hdr_lines;
    logic [63:0] bound_word [NUM_WORD_REGS];
    phase_e      phase;
    int unsigned match_cnt;
    logic [2:0]  lines_done;
    bit          cr_held;
    bit          finished;
    result_t     extracted_q [$];
    result_t     step_buf [64];
    int          step_cnt;
    int          errors;
    int          n_body;
    int          n_done;
    int          n_err [4];

    function new();
      bound_len = 6'd1;
      hdr_lines = 3'd2;
      foreach (bound_word[i]) bound_word[i] = '0;
      restart();
      errors = 0;
      n_body = 0;
      n_done = 0;
      foreach (n_err[i]) n_err[i] = 0;
    endfunction

    function void restart();
      phase      = PH_SEEK;
      match_cnt  = 0;
      lines_done = '0;
      cr_held    = 1'b0;
      finished   = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] v);
      case (idx)
        REG_BLEN:   bound_len = v[5:0];
        REG_HLINES: hdr_lines = v[2:0];
        default:    bound_word[idx - REG_WORD0] = v;
      endcase
    endfunction

    function int unsigned eff_len();
      return (bound_len > MAX_BOUNDARY) ? MAX_BOUNDARY : bound_len;
    endfunction

    // Character p of "--" boundary "--"
    function logic [7:0] pat(int unsigned p);
      int unsigned i;
      if (p < 2 || p >= eff_len() + 2) return CH_DASH;
      i = p - 2;
      return bound_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function int pending();
      return extracted_q.size();
    endfunction

    function void emit(kind_e k, logic [7:0] d, err_e e);
      step_buf[step_cnt] = '{kind: k, data: d, err: e, last: 1'b0};
      step_cnt++;
    endfunction

    function void abort(err_e e);
      emit(KIND_ERROR, 8'h00, e);
      finished = 1'b1;
    endfunction

    function void body_byte(logic [7:0] b);
      if (b == CH_CR) cr_held = 1'b1;
      else emit(KIND_BODY, b, ERR_NONE);
    endfunction

    function void line_error();
      if (phase == PH_CRLF) abort(ERR_NO_CRLF);
      else abort(ERR_NO_BLANK);
    endfunction

    function void parse_byte(logic [7:0] b);
      int unsigned span;
      span = eff_len();
      case (phase)
        PH_SEEK: begin
          // a broken partial match restarts and retries the same byte
          if (b != pat(match_cnt) && match_cnt > 0) match_cnt = 0;
          if (b == pat(match_cnt)) begin
            match_cnt++;
            if (match_cnt == span + 2) begin
              match_cnt = 0;
              cr_held   = 1'b0;
              phase     = PH_CRLF;
            end
          end
        end
        PH_CRLF, PH_BLANK: begin
          if (!cr_held) begin
            if (b == CH_CR) cr_held = 1'b1;
            else line_error();
          end else if (b == CH_LF) begin
            cr_held = 1'b0;
            if (phase == PH_BLANK) begin
              phase = PH_BODY;
            end else begin
              lines_done = '0;
              phase = (hdr_lines == 0) ? PH_BLANK : PH_HEAD;
            end
          end else begin
            line_error();
          end
        end
        PH_HEAD: begin
          if (cr_held && b == CH_LF) begin
            cr_held    = 1'b0;
            lines_done = lines_done + 3'd1;
            if (lines_done >= hdr_lines) phase = PH_BLANK;
          end else begin
            cr_held = (b == CH_CR);
          end
        end
        PH_BODY: begin
          if (cr_held && b == CH_LF) begin
            cr_held   = 1'b0;
            match_cnt = 0;
            phase     = PH_TERM;
          end else begin
            if (cr_held) begin
              cr_held = 1'b0;
              emit(KIND_BODY, CH_CR, ERR_NONE);
            end
            body_byte(b);
          end
        end
        default: begin
          if (b == pat(match_cnt)) begin
            match_cnt++;
            if (match_cnt == span + 4) begin
              emit(KIND_DONE, 8'h00, ERR_NONE);
              finished = 1'b1;
            end
          end else begin
            // replay the held CR LF and matched characters, then the byte
            emit(KIND_BODY, CH_CR, ERR_NONE);
            emit(KIND_BODY, CH_LF, ERR_NONE);
            for (int unsigned k = 0; k < match_cnt; k++) emit(KIND_BODY, pat(k), ERR_NONE);
            match_cnt = 0;
            phase     = PH_BODY;
            body_byte(b);
          end
        end
      endcase
    endfunction

    // Called for every accepted input transaction
    function void note_input(logic [7:0] b, logic first, logic fin);
      result_t r;
      step_cnt = 0;
      if (first) restart();
      if (finished) return;
      parse_byte(b);
      if (!finished && fin) abort(ERR_EARLY_END);
      for (int i = 0; i < step_cnt; i++) begin
        r = step_buf[i];
        r.last = (i == step_cnt - 1);
        extracted_q.push_back(r);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Called for every accepted result transaction
    task check_result(result_t got);
      result_t want;
      if (extracted_q.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d byte %02h code %0d",
                         got.kind, got.data, got.err));
        return;
      end
      want = extracted_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.data !== want.data)
        report($sformatf("out_byte %02h, want %02h", got.data, want.data));
      if (got.err !== want.err)
        report($sformatf("error_code %0d, want %0d", got.err, want.err));
      if (got.last !== want.last)
        report($sformatf("last_of_run %0b, want %0b", got.last, want.last));
      case (want.kind)
        KIND_BODY: n_body++;
        KIND_DONE: n_done++;
        default:   n_err[want.err]++;
      endcase
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_idx_i    = '0;
  logic [63:0] cfg_wdata_i  = '0;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i    = '0;
  logic        first_byte_i = 1'b0;
  logic        final_byte_i = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  multipart_body_extractor_unit #(
    .MAX_BOUNDARY(MAX_BOUNDARY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .first_byte_i (first_byte_i),
    .final_byte_i (final_byte_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .error_code_o (error_code_o),
    .last_of_run_o(last_of_run_o)
  );

  extractor_scoreboard sb = new();

  stim_t       upload_q [$];            // bytes of the upload being built
  logic [63:0] cfg_words [NUM_WORD_REGS];
  int unsigned idle_odds   = 6;          // 1-in-N chance of a stall burst; 0 = none
  int          pop_hold    = 0;
  int          total_items = 0;
  int          rand_items  = 0;
  int          settings    = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a healthy run finishes well inside this
  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: pop with random stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (pop_hold > 0) pop_hold--;
      else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
        pop_hold = $urandom_range(1, 10);
      pop <= (pop_hold == 0);
    end
  end

  // Both handshakes are sampled at the clock edge, before any update of this
  // edge lands, so accepted transactions are seen exactly as the DUT saw them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_input(in_byte_i, first_byte_i, final_byte_i);
      if (pop && !empty)
        sb.check_result('{kind: kind_e'(kind_o), data: out_byte_o,
                          err: err_e'(error_code_o), last: last_of_run_o});
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    stim_t s;
    s.b     = b;
    s.first = (upload_q.size() == 0);  // every upload opens with a restart
    s.fin   = 1'b0;
    upload_q.push_back(s);
  endfunction

  // Flag the last queued byte as end of stream
  function automatic void mark_end();
    stim_t tail;
    tail = upload_q.pop_back();
    tail.fin = 1'b1;
    upload_q.push_back(tail);
  endfunction

  function automatic logic [7:0] pick_other(logic [7:0] avoid);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == avoid);
    return v;
  endfunction

  // Junk that often looks like the start of a delimiter
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return CH_DASH;
      1:       return sb.pat(2);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds one upload for the current settings. Most are well formed with
  // random headers and body; the rest break the opening CR LF, break the
  // blank line, stop early (with or without end of stream) or are pure noise.
  function automatic void build_upload();
    int unsigned span, variant, n, k, cut;
    span    = sb.eff_len() + 2;  // length of "--" boundary
    variant = $urandom_range(0, 19);
    upload_q.delete();
    if (variant == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) add_byte(noise_byte());
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) add_byte(noise_byte());
      // false start: part of the delimiter, then a wrong byte
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, span - 1);
        for (int unsigned i = 0; i < k; i++) add_byte(sb.pat(i));
        add_byte(pick_other(sb.pat(k)));
      end
      for (int unsigned i = 0; i < span; i++) add_byte(sb.pat(i));
      if (variant == 1) begin
        add_byte(pick_other(CH_CR));
      end else if (variant == 2) begin
        add_byte(CH_CR);
        add_byte(pick_other(CH_LF));
      end else begin
        add_byte(CH_CR);
        add_byte(CH_LF);
        for (int unsigned i = 0; i < sb.hdr_lines; i++) begin
          n = $urandom_range(0, 4);
          repeat (n) add_byte(8'($urandom_range(32, 126)));
          if ($urandom_range(0, 5) == 0) begin
            add_byte(CH_CR);  // stray CR inside a header line
            add_byte(8'($urandom_range(32, 126)));
          end
          add_byte(CH_CR);
          add_byte(CH_LF);
        end
        if (variant == 3) begin
          add_byte(pick_other(CH_CR));
        end else if (variant == 4) begin
          add_byte(CH_CR);
          add_byte(pick_other(CH_LF));
        end else begin
          add_byte(CH_CR);
          add_byte(CH_LF);
          n = $urandom_range(0, 12);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0: add_byte(CH_CR);
              1: add_byte(CH_LF);
              2: begin
                // terminator lookalike that breaks after k characters
                add_byte(CH_CR);
                add_byte(CH_LF);
                k = $urandom_range(0, span + 1);
                for (int unsigned i = 0; i < k; i++) add_byte(sb.pat(i));
                add_byte(pick_other(sb.pat(k)));
              end
              default: add_byte(8'($urandom_range(0, 255)));
            endcase
          end
          add_byte(CH_CR);
          add_byte(CH_LF);
          for (int unsigned i = 0; i < span + 2; i++) add_byte(sb.pat(i));
          if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    // variant 5 stops early at end of stream, variant 6 is simply abandoned
    if (variant == 5 || variant == 6) begin
      cut = $urandom_range(1, upload_q.size() - 1);
      while (upload_q.size() > cut) void'(upload_q.pop_back());
    end
    if (variant == 5 || (variant != 6 && $urandom_range(0, 2) == 0)) mark_end();
  endfunction

  task automatic send_byte(stim_t s);
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push         <= 1'b1;
    in_byte_i    <= s.b;
    first_byte_i <= s.first;
    final_byte_i <= s.fin;
    do @(posedge clk_i); while (full);
    total_items++;
  endtask

  task automatic send_upload();
    foreach (upload_q[i]) send_byte(upload_q[i]);
  endtask

  // Stop pushing and wait until every pending result is out, then let any
  // byte that produces nothing clear the pipeline.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  // Writes every register; unused upper bits carry junk the DUT must ignore
  task automatic load_config(logic [5:0] len, logic [2:0] hl);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    write_reg(REG_BLEN, {junk[63:6], len});
    junk = {$urandom(), $urandom()};
    write_reg(REG_HLINES, {junk[63:3], hl});
    for (int i = 0; i < NUM_WORD_REGS; i++)
      write_reg(cfg_reg_e'(REG_WORD0 + i), cfg_words[i]);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          p;
    int          phase_items;
    logic [5:0]  len;
    logic [2:0]  hl;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, on reset settings: one-character boundary 0x00, two header
    // lines. Header line "q", empty header line, lone CR in body, a terminator
    // lookalike that breaks after one dash, a clean finish, a byte after
    // completion, then an early end and a missing CR LF after the opening.
    upload_q.delete();
    add_byte(CH_DASH); add_byte(CH_DASH); add_byte(8'h00); add_byte(CH_CR); add_byte(CH_LF);
    add_byte("q"); add_byte(CH_CR); add_byte(CH_LF); add_byte(CH_CR); add_byte(CH_LF);
    add_byte(CH_CR); add_byte(CH_LF);
    add_byte(8'hFF); add_byte(CH_CR); add_byte(8'h00);
    add_byte(CH_CR); add_byte(CH_LF); add_byte(CH_DASH); add_byte(8'h07);
    add_byte(CH_CR); add_byte(CH_LF); add_byte(CH_DASH); add_byte(CH_DASH); add_byte(8'h00);
    add_byte(CH_DASH); add_byte(CH_DASH);
    add_byte("k");
    send_upload();
    upload_q.delete();
    add_byte(CH_DASH);
    mark_end();
    send_upload();
    upload_q.delete();
    add_byte(CH_DASH); add_byte(CH_DASH); add_byte(8'h00); add_byte("x");
    send_upload();

    // Random part: each pass drains the DUT, picks new settings (empty,
    // single, full-size and oversized boundaries; zero to seven header
    // lines) and streams uploads through them.
    p = 0;
    while (rand_items < ITEM_GOAL) begin
      drain();
      case (p % 9)
        0:       len = 6'($urandom_range(2, 6));
        1:       len = 6'd0;
        2:       len = 6'(MAX_BOUNDARY);
        3:       len = 6'd1;
        4:       len = 6'($urandom_range(7, 16));
        5:       len = 6'($urandom_range(MAX_BOUNDARY + 1, 63));
        6:       len = 6'($urandom_range(17, 30));
        7:       len = 6'($urandom_range(2, 4));
        default: len = 6'($urandom_range(1, 8));
      endcase
      case (p % 6)
        0:       hl = 3'd1;
        1:       hl = 3'd0;
        2:       hl = 3'd7;
        3:       hl = 3'd2;
        4:       hl = 3'($urandom_range(3, 6));
        default: hl = 3'd4;
      endcase
      for (int i = 0; i < NUM_WORD_REGS; i++) begin
        if (p % 4 == 1) cfg_words[i] = '0;
        else if (p % 4 == 3) cfg_words[i] = '1;
        else begin
          for (int j = 0; j < 8; j++)
            cfg_words[i][j*8 +: 8] = ($urandom_range(0, 7) == 0) ?
                                     8'($urandom_range(0, 255)) :
                                     8'($urandom_range(33, 126));
        end
      end
      load_config(len, hl);

      if (rand_items >= CALM_FROM) idle_odds = 0;
      else case (p % 3)
        0:       idle_odds = 0;
        1:       idle_odds = 4;
        default: idle_odds = 12;
      endcase

      // long boundaries get a single upload, short ones several
      phase_items = 0;
      do begin
        build_upload();
        send_upload();
        phase_items += upload_q.size();
      end while (sb.eff_len() < 40 && phase_items < 45);
      rand_items += phase_items;
      p++;
    end

    idle_odds = 0;
    drain();

    $display("Covered %0d bytes over %0d register settings: %0d body bytes, %0d completions,",
             total_items, settings, sb.n_body, sb.n_done);
    $display("  status errors %0d missing CR LF, %0d missing blank line, %0d early end.",
             sb.n_err[ERR_NO_CRLF], sb.n_err[ERR_NO_BLANK], sb.n_err[ERR_EARLY_END]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
